[sv/mcbm_pkg.sv]
// ----------------------------------------------------------------------------
// mcbm_pkg
// types and constants shared by the multicart bank mapper modules
// ----------------------------------------------------------------------------
package mcbm_pkg;

	// access kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_RESET = 2'd2;

	// bank layout modes taken from data bits 7..6
	localparam logic [1:0] MODE_FIXED_HIGH  = 2'd0;
	localparam logic [1:0] MODE_MASKED_LOW  = 2'd1;
	localparam logic [1:0] MODE_MIRROR_16K  = 2'd2;
	localparam logic [1:0] MODE_BANK_32K    = 2'd3;

	localparam logic [15:0] ADDR_DIP   = 16'hC000;
	localparam logic [2:0]  BANK_LAST  = 3'h7;
	localparam logic [2:0]  INNER_EVEN = 3'h6;
	localparam logic [5:0]  HIGH_BANK_RESET = 6'd7;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] address;
		logic [7:0]  write_data;
	} cmd_item_t;

	typedef struct packed {
		logic [5:0] low_window_bank;
		logic [5:0] high_window_bank;
		logic       horizontal_mirror;
		logic       dip_read_valid;
		logic [2:0] dip_read_value;
	} res_item_t;

	typedef struct packed {
		logic       lock_flag;
		logic       outer_high_bit;
		logic [1:0] outer_pair;
		logic [5:0] low_bank;
		logic [5:0] high_bank;
		logic       mirror_select;
		logic [1:0] dip_setting;
	} map_state_t;

endpackage

[sv/mcbm_decode.sv]
// ----------------------------------------------------------------------------
// mcbm_decode
// decodes one access against the current mapping: next mapping and result
// ----------------------------------------------------------------------------
module mcbm_decode (
	input  mcbm_pkg::cmd_item_t  cmd,
	input  mcbm_pkg::map_state_t cur,
	output mcbm_pkg::map_state_t nxt,
	output mcbm_pkg::res_item_t  res
);

	logic [2:0] inner;
	logic [2:0] inner_even;
	logic [1:0] mode;
	logic [5:0] new_base;
	logic [5:0] old_base;
	logic       dip_hit;

	assign inner      = cmd.write_data[2:0];
	assign inner_even = inner & mcbm_pkg::INNER_EVEN;
	assign mode       = cmd.write_data[7:6];
	assign new_base   = {cmd.address[2], cmd.write_data[4:3], 3'b000};
	assign old_base   = {cur.outer_high_bit, cur.outer_pair, 3'b000};

	always_comb begin
		nxt     = cur;
		dip_hit = 1'b0;
		case (cmd.kind)
			mcbm_pkg::KIND_WRITE: begin
				if (cur.lock_flag) begin
					// locked: only the inner bank moves
					nxt.low_bank  = old_base | {3'b000, inner};
					nxt.high_bank = old_base | {3'b000, mcbm_pkg::BANK_LAST};
				end else begin
					nxt.lock_flag      = cmd.address[1];
					nxt.outer_high_bit = cmd.address[2];
					nxt.outer_pair     = cmd.write_data[4:3];
					nxt.mirror_select  = cmd.write_data[5];
					case (mode)
						mcbm_pkg::MODE_FIXED_HIGH: begin
							nxt.low_bank  = new_base | {3'b000, inner};
							nxt.high_bank = new_base | {3'b000, mcbm_pkg::BANK_LAST};
						end
						mcbm_pkg::MODE_MASKED_LOW: begin
							nxt.low_bank  = new_base | {3'b000, inner_even};
							nxt.high_bank = new_base | {3'b000, mcbm_pkg::BANK_LAST};
						end
						mcbm_pkg::MODE_MIRROR_16K: begin
							nxt.low_bank  = new_base | {3'b000, inner};
							nxt.high_bank = new_base | {3'b000, inner};
						end
						default: begin
							// one 32K bank: even half low, odd half high
							nxt.low_bank  = new_base | {3'b000, inner_even};
							nxt.high_bank = new_base | {3'b000, inner_even} | 6'd1;
						end
					endcase
				end
			end
			mcbm_pkg::KIND_READ: begin
				dip_hit = (cmd.address == mcbm_pkg::ADDR_DIP);
			end
			mcbm_pkg::KIND_RESET: begin
				nxt.lock_flag      = 1'b0;
				nxt.outer_high_bit = 1'b0;
				nxt.outer_pair     = 2'd0;
				nxt.low_bank       = 6'd0;
				nxt.high_bank      = mcbm_pkg::HIGH_BANK_RESET;
				nxt.dip_setting    = cur.dip_setting + 2'd1;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_comb begin
		res.low_window_bank   = nxt.low_bank;
		res.high_window_bank  = nxt.high_bank;
		res.horizontal_mirror = nxt.mirror_select;
		res.dip_read_valid    = dip_hit;
		res.dip_read_value    = dip_hit ? ({1'b0, cur.dip_setting} + 3'd1) : 3'd0;
	end

endmodule

[sv/multicart_bank_mapper.sv]
// ----------------------------------------------------------------------------
// multicart_bank_mapper
// prg bank and mirroring control of a multicart cartridge
// ----------------------------------------------------------------------------
// Each item on cmd is one cpu access (write, read) or a soft reset; each gives
// exactly one item on res carrying the 16K banks now mapped at 0x8000 and
// 0xC000, the mirroring, and for a read of 0xC000 the dip setting plus one.
// An item is registered on entry, decoded against the mapping state and
// written to the result register together with the state update, so
// res_valid follows the entry register and the result register in turn;
// one item is taken every cycle while res is not stalled. A stall on res
// holds the result register and the entry register and then shows up on
// cmd_stall in the same cycle. Reset sets the mapping to banks 0 and 7,
// unlocked, vertical mirroring and dip setting 0.
module multicart_bank_mapper (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  mcbm_pkg::cmd_item_t cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output mcbm_pkg::res_item_t res
);

	// entry register
	logic                 vld_s1;
	mcbm_pkg::cmd_item_t  cmd_s1;

	// mapping state and result register
	mcbm_pkg::map_state_t state_q;
	mcbm_pkg::map_state_t state_nxt;
	mcbm_pkg::res_item_t  res_nxt;
	logic                 vld_s2;
	mcbm_pkg::res_item_t  res_s2;

	logic                 advance;

	// item in s1 moves on when the result register is free or draining
	assign advance   = vld_s1 && (!vld_s2 || !res_stall);
	assign cmd_stall = vld_s1 && !advance;

	mcbm_decode u_decode (
		.cmd (cmd_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// mapping state commits only when its item leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.lock_flag      <= 1'b0;
			state_q.outer_high_bit <= 1'b0;
			state_q.outer_pair     <= 2'd0;
			state_q.low_bank       <= 6'd0;
			state_q.high_bank      <= mcbm_pkg::HIGH_BANK_RESET;
			state_q.mirror_select  <= 1'b0;
			state_q.dip_setting    <= 2'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (!res_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign res_valid = vld_s2;
	assign res       = res_s2;

endmodule

[dv/mcbm_mapping_checker.sv]
// ----------------------------------------------------------------------------
// mcbm_mapping_checker
// watches both channels of the bank mapper and checks every result item
// ----------------------------------------------------------------------------
// Keeps its own copy of the mapping state. Every accepted access moves that
// state and queues the expected result. Every accepted result is compared
// field by field against the oldest queued one.
module mcbm_mapping_checker
	import mcbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  cmd_item_t   cmd,
	input  logic        res_valid,
	input  logic        res_stall,
	input  res_item_t   res,
	output int unsigned mismatch_count,
	output int unsigned pending_results
);

	map_state_t cart;
	res_item_t  expected_mappings[$];
	res_item_t  want;
	logic       field_bad;

	// mapping state after one access
	function automatic map_state_t next_mapping(map_state_t s, cmd_item_t c);
		map_state_t n;
		logic [2:0] outer;
		logic [2:0] inner;
		n = s;
		case (c.kind)
			KIND_WRITE: begin
				if (s.lock_flag) begin
					// locked: only the inner bank moves, data bits 2..0
					outer = {s.outer_high_bit, s.outer_pair};
					n.low_bank = {outer, c.write_data[2:0]};
					n.high_bank = {outer, BANK_LAST};
				end else begin
					n.lock_flag = c.address[1];
					n.outer_high_bit = c.address[2];
					n.outer_pair = c.write_data[4:3];
					n.mirror_select = c.write_data[5];
					outer = {c.address[2], c.write_data[4:3]};
					inner = c.write_data[2:0];
					case (c.write_data[7:6])
						MODE_FIXED_HIGH: begin
							n.low_bank = {outer, inner};
							n.high_bank = {outer, BANK_LAST};
						end
						MODE_MASKED_LOW: begin
							n.low_bank = {outer, inner & INNER_EVEN};
							n.high_bank = {outer, BANK_LAST};
						end
						MODE_MIRROR_16K: begin
							n.low_bank = {outer, inner};
							n.high_bank = {outer, inner};
						end
						default: begin
							n.low_bank = {outer, inner & INNER_EVEN};
							n.high_bank = {outer, (inner & INNER_EVEN) | 3'd1};
						end
					endcase
				end
			end
			KIND_RESET: begin
				// mirroring survives a soft reset
				n.lock_flag = 1'b0;
				n.outer_high_bit = 1'b0;
				n.outer_pair = 2'd0;
				n.low_bank = 6'd0;
				n.high_bank = HIGH_BANK_RESET;
				n.dip_setting = s.dip_setting + 2'd1;
			end
			default: ;
		endcase
		return n;
	endfunction

	function automatic res_item_t mapping_result(map_state_t s, cmd_item_t c);
		res_item_t r;
		r.low_window_bank = s.low_bank;
		r.high_window_bank = s.high_bank;
		r.horizontal_mirror = s.mirror_select;
		r.dip_read_valid = (c.kind == KIND_READ) && (c.address == ADDR_DIP);
		r.dip_read_value = r.dip_read_valid ? {1'b0, s.dip_setting} + 3'd1 : 3'd0;
		return r;
	endfunction

	function automatic string describe(res_item_t r);
		return $sformatf("low %02h high %02h hmirror %0b dip_valid %0b dip %0d",
			r.low_window_bank, r.high_window_bank, r.horizontal_mirror,
			r.dip_read_valid, r.dip_read_value);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart = '0;
			cart.high_bank = HIGH_BANK_RESET;
			expected_mappings.delete();
			mismatch_count <= 0;
			pending_results <= 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				cart = next_mapping(cart, cmd);
				expected_mappings.push_back(mapping_result(cart, cmd));
			end
			if (res_valid && !res_stall) begin
				if (expected_mappings.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result item with nothing expected: %s",
							$time, describe(res));
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_mappings.pop_front();
					field_bad = (res.low_window_bank !== want.low_window_bank)
						|| (res.high_window_bank !== want.high_window_bank)
						|| (res.horizontal_mirror !== want.horizontal_mirror)
						|| (res.dip_read_valid !== want.dip_read_valid)
						|| (res.dip_read_value !== want.dip_read_value);
					if (field_bad) begin
						if (mismatch_count < 10)
							$display("%0t: mismatch, expected %s, got %s",
								$time, describe(want), describe(res));
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			pending_results <= expected_mappings.size();
		end
	end

endmodule

[dv/tb_multicart_bank_mapper.sv]
// ----------------------------------------------------------------------------
// tb_multicart_bank_mapper
// stimulus and verdict for the multicart bank mapper
// ----------------------------------------------------------------------------
// A directed run walks every access kind, every bank mode, locking, the
// masked locked write and the dip setting wrapping over soft resets. Random
// accesses follow, in four idling phases, while a separate checker predicts
// and compares every result item.
module tb_multicart_bank_mapper;
	import mcbm_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_item_t   cmd;
	logic        res_valid;
	logic        res_stall;
	res_item_t   res;
	int unsigned mismatch_count;
	int unsigned pending_results;

	// chance per cycle, in percent, of an idle cycle on each side
	int unsigned send_idle_pct;
	int unsigned stall_pct;

	multicart_bank_mapper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	mcbm_mapping_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.cmd             (cmd),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.res             (res),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic cmd_item_t access(logic [1:0] k, logic [15:0] a, logic [7:0] d);
		cmd_item_t c;
		c.kind = k;
		c.address = a;
		c.write_data = d;
		return c;
	endfunction

	// offer one item, with random idle cycles ahead of it, and hold it
	// until the block takes it
	task automatic send_access(input cmd_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= item;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	// mostly writes and reads of the dip address; soft resets often enough
	// that the lock does not stick and unlocked writes keep coming
	task automatic send_random_accesses(input int unsigned count);
		cmd_item_t   c;
		int unsigned pick;
		repeat (count) begin
			pick = $urandom_range(99);
			c = access(KIND_WRITE, 16'($urandom_range(16'hFFFF)),
				8'($urandom_range(8'hFF)));
			if (pick < 15) begin
				c.kind = KIND_RESET;
			end else if (pick < 50) begin
				c.kind = KIND_READ;
				if ($urandom_range(1) == 0)
					c.address = ADDR_DIP;
			end else begin
				// lock bit set on about a third of writes
				c.address[1] = ($urandom_range(99) < 30);
			end
			send_access(c);
		end
	endtask

	initial begin
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		res_stall <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads from the reset mapping, dip read and near misses
		send_access(access(KIND_READ, ADDR_DIP, 8'h00));
		send_access(access(KIND_READ, 16'hC001, 8'hFF));
		send_access(access(KIND_READ, 16'h0000, 8'h00));
		send_access(access(KIND_READ, 16'hFFFF, 8'hFF));
		// unlocked writes covering every bank mode, outer bits on and off
		send_access(access(KIND_WRITE, 16'h8000, 8'h00));
		send_access(access(KIND_WRITE, 16'h8004, 8'h3F));
		send_access(access(KIND_WRITE, 16'hFFF9, 8'h7D));
		send_access(access(KIND_WRITE, 16'h8004, 8'hBB));
		send_access(access(KIND_WRITE, 16'h8000, 8'hC7));
		// lock with every address and data bit set, then locked writes
		// whose upper data bits must be dropped
		send_access(access(KIND_WRITE, 16'hFFFF, 8'hFF));
		send_access(access(KIND_WRITE, 16'h0000, 8'hFF));
		send_access(access(KIND_WRITE, 16'h8000, 8'hF8));
		send_access(access(KIND_READ, ADDR_DIP, 8'h00));
		// soft resets unlock and walk the dip setting around its wrap
		send_access(access(KIND_RESET, 16'hFFFF, 8'hFF));
		send_access(access(KIND_READ, ADDR_DIP, 8'hFF));
		send_access(access(KIND_RESET, 16'h0000, 8'h00));
		send_access(access(KIND_READ, ADDR_DIP, 8'h00));
		send_access(access(KIND_RESET, 16'hC000, 8'h55));
		send_access(access(KIND_READ, ADDR_DIP, 8'h00));
		send_access(access(KIND_RESET, 16'h8000, 8'hAA));
		send_access(access(KIND_READ, ADDR_DIP, 8'h00));
		// lock through address bit 1 alone, masked mode, then a locked write
		send_access(access(KIND_WRITE, 16'h0002, 8'h47));
		send_access(access(KIND_WRITE, 16'h8000, 8'h00));
		send_access(access(KIND_RESET, 16'h0000, 8'h00));

		// random part, one idling phase after another
		send_random_accesses(115);
		send_idle_pct = 82;
		send_random_accesses(110);
		send_idle_pct = 0;
		stall_pct = 82;
		send_random_accesses(110);
		send_idle_pct = 25;
		stall_pct = 25;
		send_random_accesses(115);
		cmd_valid <= 1'b0;

		// let the checker count the last item, drain, then keep running
		// to catch any stray result item
		repeat (2) @(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatch_count == 0 && pending_results == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// hang guard, far above the slowest legal run
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
